### src/pcg_pkg.sv
// Shared widths, constants and the output permutation of the bounded random generator.
package pcg_pkg;

  localparam int RANGE_W = 31;
  localparam int WORD_W  = 32;
  localparam int STATE_W = 64;

  // The divider walks one dividend bit per cycle over a 33-bit dividend,
  // which is wide enough for 2^32 as well as for any 32-bit word.
  localparam int DIV_STEPS = WORD_W + 1;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [STATE_W-1:0] PCG_MULT = 64'd6364136223846793005;

  localparam int XSH_SHIFT  = 18;
  localparam int XSH_DROP   = 27;
  localparam int ROT_OFFSET = 59;

  // XSH RR output word taken from the state before a step.
  function automatic logic [WORD_W-1:0] xsh_rr(input logic [STATE_W-1:0] prev);
    logic [STATE_W-1:0]  folded;
    logic [WORD_W-1:0]   mixed;
    logic [4:0]          amount;
    logic [2*WORD_W-1:0] doubled;
    folded  = ((prev >> XSH_SHIFT) ^ prev) >> XSH_DROP;
    mixed   = folded[WORD_W-1:0];
    amount  = prev[ROT_OFFSET+4:ROT_OFFSET];
    doubled = {mixed, mixed} >> amount;
    return doubled[WORD_W-1:0];
  endfunction

endpackage

### src/pcg_if.sv
// Valid/ready channel interfaces for the request, result and configuration ports.
interface pcg_in_if import pcg_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [RANGE_W-1:0] range_count;
  modport source (output valid, output range_count, input ready);
  modport sink   (input valid, input range_count, output ready);
  modport mon    (input valid, input range_count, input ready);
endinterface

interface pcg_out_if import pcg_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [RANGE_W-1:0] chosen_value;
  modport source (output valid, output chosen_value, input ready);
  modport sink   (input valid, input chosen_value, output ready);
  modport mon    (input valid, input chosen_value, input ready);
endinterface

interface pcg_cfg_if import pcg_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [STATE_W-1:0] stream_increment;
  modport source (output valid, output stream_increment, input ready);
  modport sink   (input valid, input stream_increment, output ready);
  modport mon    (input valid, input stream_increment, input ready);
endinterface

### src/pcg32_bounded_random_core.sv
// Bounded uniform random source: PCG32 XSH RR generator with rejection and modulo reduction.
//
// Usage: a transaction on in_ch carries range_count n and asks for one value drawn
// uniformly from 0 to n-1; that value leaves as one transaction on out_ch. The
// stream increment is written through cfg_ch, which is always ready, and must only be
// written while no request is in flight.
// Operation: a request of n = 0 yields zero without stepping the generator. Otherwise
// the shared restoring divider first forms 2^32 mod n, then each generator step runs
// through states MUL0 to MUL3 on the shared 32x32 multiplier, and a rejected word costs
// another step. The accepted word is reduced by a second pass through the divider,
// and the block handles one request at a time.
// Reset: the generator state and the stream increment return to zero and any result
// waiting in the output register is dropped.
// Stalls: the result sits in an output register, so a new request is accepted while a
// finished result still waits; a second finished result waits in its final state
// until the output register frees up.
module pcg32_bounded_random_core
  import pcg_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  pcg_in_if.sink   in_ch,
  pcg_out_if.source out_ch,
  pcg_cfg_if.sink  cfg_ch
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LIMIT,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_MOD,
    ST_DONE
  } state_t;

  state_t               state_r;
  logic [STATE_W-1:0]   inc_r;
  logic [STATE_W-1:0]   gen_r;
  logic [STATE_W-1:0]   prod_r;
  logic [STATE_W-1:0]   acc_r;
  logic [RANGE_W-1:0]   n_r;
  logic [WORD_W-1:0]    limit_r;
  logic [WORD_W-1:0]    word_r;
  logic [RANGE_W-1:0]   rem_r;
  logic [DIV_STEPS-1:0] dvd_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [RANGE_W-1:0]   res_r;
  logic                 out_valid_r;
  logic [RANGE_W-1:0]   out_data_r;

  // Shared restoring divider step: bring in one dividend bit, subtract n if it fits.
  logic [WORD_W-1:0]    trial;
  logic [WORD_W:0]      diff;
  logic [RANGE_W-1:0]   rem_nxt;

  // Shared multiplier: the low 64 bits of the LCG product are built from three
  // 32x32 partial products, one per cycle.
  logic [WORD_W-1:0]    mul_a;
  logic [WORD_W-1:0]    mul_b;
  logic [STATE_W-1:0]   mul_p;

  logic                 in_acc;
  logic                 out_acc;
  logic                 out_load;

  assign trial   = {rem_r, dvd_r[DIV_STEPS-1]};
  assign diff    = {1'b0, trial} - {2'b00, n_r};
  assign rem_nxt = diff[WORD_W] ? trial[RANGE_W-1:0] : diff[RANGE_W-1:0];

  always_comb begin
    mul_a = gen_r[WORD_W-1:0];
    mul_b = PCG_MULT[WORD_W-1:0];
    case (state_r)
      ST_MUL1: mul_b = PCG_MULT[STATE_W-1:WORD_W];
      ST_MUL2: mul_a = gen_r[STATE_W-1:WORD_W];
      default: ;
    endcase
  end

  assign mul_p = STATE_W'(mul_a) * STATE_W'(mul_b);

  assign in_ch.ready         = (state_r == ST_IDLE);
  assign in_acc              = in_ch.valid && in_ch.ready;
  assign out_acc             = out_valid_r && out_ch.ready;
  // A finished result moves into the output register once that register is free or
  // is being emptied in the same cycle.
  assign out_load            = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.chosen_value = out_data_r;
  assign cfg_ch.ready        = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      inc_r       <= '0;
      gen_r       <= '0;
    end else begin
      if (cfg_ch.valid) begin
        inc_r <= cfg_ch.stream_increment;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_acc) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            n_r   <= in_ch.range_count;
            rem_r <= '0;
            dvd_r <= {1'b1, {WORD_W{1'b0}}};
            cnt_r <= DIV_CNT_W'(DIV_STEPS - 1);
            if (in_ch.range_count == '0) begin
              // A zero range has no meaning: return zero, leave the generator alone.
              res_r   <= '0;
              state_r <= ST_DONE;
            end else begin
              state_r <= ST_LIMIT;
            end
          end
        end
        ST_LIMIT: begin
          rem_r <= rem_nxt;
          dvd_r <= dvd_r << 1;
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            // Largest word that keeps the draw unbiased: 2^32 - 1 - (2^32 mod n).
            limit_r <= {WORD_W{1'b1}} - {1'b0, rem_nxt};
            state_r <= ST_MUL0;
          end
        end
        ST_MUL0: begin
          prod_r  <= mul_p;
          word_r  <= xsh_rr(gen_r);
          state_r <= ST_MUL1;
        end
        ST_MUL1: begin
          acc_r   <= prod_r + (inc_r | STATE_W'(1));
          prod_r  <= mul_p;
          state_r <= ST_MUL2;
        end
        ST_MUL2: begin
          acc_r   <= acc_r + {prod_r[WORD_W-1:0], {WORD_W{1'b0}}};
          prod_r  <= mul_p;
          state_r <= ST_MUL3;
        end
        ST_MUL3: begin
          gen_r <= acc_r + {prod_r[WORD_W-1:0], {WORD_W{1'b0}}};
          if (word_r > limit_r) begin
            state_r <= ST_MUL0;
          end else begin
            rem_r   <= '0;
            dvd_r   <= {1'b0, word_r};
            cnt_r   <= DIV_CNT_W'(DIV_STEPS - 1);
            state_r <= ST_MOD;
          end
        end
        ST_MOD: begin
          rem_r <= rem_nxt;
          dvd_r <= dvd_r << 1;
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            res_r   <= rem_nxt;
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            out_data_r  <= res_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

### src/pcg_chk.sv
// Port-level checker for the bounded random core, attached by bind.
module pcg_chk
  import pcg_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  pcg_in_if.sink    in_ch,
  pcg_out_if.source out_ch
);

  logic               in_acc;
  logic               out_acc;
  logic [1:0]         pend_r;
  logic [RANGE_W-1:0] n_last_r;

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r   <= '0;
      n_last_r <= '0;
    end else begin
      pend_r <= pend_r + {1'b0, in_acc} - {1'b0, out_acc};
      if (in_acc) begin
        n_last_r <= in_ch.range_count;
      end
    end
  end

  // The core works on one request at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ch.ready)
    else $error("request accepted while the previous one is still in work");

  // A result only appears for a request that has not yet been answered.
  a_no_invented_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> pend_r != 2'd0)
    else $error("result shown with no request outstanding");

  // With one request outstanding, the result lies below its range, or is zero for a range of zero.
  a_value_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && pend_r == 2'd1) |->
      (out_ch.chosen_value < n_last_r) ||
      (n_last_r == '0 && out_ch.chosen_value == '0))
    else $error("result outside the requested range");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> out_ch.valid && $stable(out_ch.chosen_value))
    else $error("stalled result changed or vanished");

endmodule

bind pcg32_bounded_random_core pcg_chk u_pcg_chk (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);
